// ----- design/swdl_pkg.sv -----
package swdl_pkg;

   localparam int STORE_DEPTH_DEFAULT = 8192;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int LENGTH_W   = 14;
   localparam int OFFSET_W   = 16;
   localparam int POSITION_W = 13;
   localparam int SAMPLE_W   = 12;
   localparam int WORD_W     = 13;
   localparam int INTERVAL_W = 17;
   localparam int PIN_W      = 16;

   localparam logic [LENGTH_W-1:0]   LENGTH_RESET    = 14'd512;
   localparam logic [OFFSET_W-1:0]   OFFSET_RESET    = 16'd2000;
   localparam logic [POSITION_W-1:0] SWEEP_MAX_RESET = 13'd200;

   localparam logic [INTERVAL_W-1:0] BASE_INTERVAL = 17'd720;
   localparam logic [WORD_W-1:0]     SAMPLE_BIAS   = 13'd100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DELAY_LENGTH = 2'd0,
      CSR_SWEEP_OFFSET = 2'd1,
      CSR_SWEEP_MAX    = 2'd2
   } csr_index_type;

   typedef enum logic {
      FUNC_SWEEP  = 1'b0,
      FUNC_SAMPLE = 1'b1
   } func_type;

   function automatic logic [PIN_W-1:0] pin_map(input logic [WORD_W-1:0] word);
      pin_map = {word[11], 3'b000, word[10:0], 1'b0};
   endfunction

endpackage

// ----- design/swdl_req_if.sv -----
interface swdl_req_if;
   import swdl_pkg::*;

   logic                valid;
   logic                ready;
   logic                func;
   logic [SAMPLE_W-1:0] sample_in;

   modport source (output valid, output func, output sample_in, input ready);
   modport sink (input valid, input func, input sample_in, output ready);
endinterface

// ----- design/swdl_rsp_if.sv -----
interface swdl_rsp_if;
   import swdl_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  result_kind;
   logic [INTERVAL_W-1:0] sample_interval;
   logic [WORD_W-1:0]     delayed_sample;
   logic [PIN_W-1:0]      pin_word;

   modport source (output valid, output result_kind, output sample_interval,
                   output delayed_sample, output pin_word, input ready);
   modport sink (input valid, input result_kind, input sample_interval,
                 input delayed_sample, input pin_word, output ready);
endinterface

// ----- design/swdl_ram.sv -----
module swdl_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a same-address read returns the old word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/swept_clock_delay_line.sv -----
// Flanger delay line with a triangle-swept sample clock. Each transfer on req_ch is
// either a sweep tick (func 0), which steps the triangle position between 0 and
// sweep_max and returns the sample interval 720 + sweep_offset + position, or an
// audio sample (func 1), which returns the word stored at the write pointer with its
// DAC pin pattern, stores sample_in + 100 there and advances the pointer, wrapping at
// delay_length. One item is taken every cycle while results are accepted; a result
// passes through the registered read of the delay store and then the output register.
// The store is read and written at the same edge, so no forwarding is needed. Words
// never written since reset read as zero through a fill count, so there is no
// clearing pass after reset. Writing delay_length resets the write pointer; CSR
// writes belong to idle periods only.
module swept_clock_delay_line #(
   parameter int STORE_DEPTH = swdl_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   swdl_req_if.sink                           req_ch,
   swdl_rsp_if.source                         rsp_ch,
   input  logic                               csr_wr_en,
   input  logic [swdl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [swdl_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import swdl_pkg::*;

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int EXT_W  = (CNT_W > LENGTH_W) ? CNT_W : LENGTH_W;

   logic [LENGTH_W-1:0]   length_ff,   length_in;
   logic [OFFSET_W-1:0]   offset_ff,   offset_in;
   logic [POSITION_W-1:0] sweep_max_ff, sweep_max_in;

   logic [ADDR_W-1:0]     ptr_ff,    ptr_in;
   logic [CNT_W-1:0]      fill_ff,   fill_in;
   logic [POSITION_W-1:0] pos_ff,    pos_in;
   logic                  rising_ff, rising_in;

   logic                  s1_valid_ff,    s1_valid_in;
   logic                  s1_kind_ff,     s1_kind_in;
   logic [INTERVAL_W-1:0] s1_interval_ff, s1_interval_in;
   logic                  s1_blank_ff,    s1_blank_in;

   logic                  out_valid_ff,    out_valid_in;
   logic                  out_kind_ff,     out_kind_in;
   logic [INTERVAL_W-1:0] out_interval_ff, out_interval_in;
   logic [WORD_W-1:0]     out_word_ff,     out_word_in;

   logic                  req_xfer;
   logic                  rsp_xfer;
   logic                  s1_advance;
   logic                  is_sample;
   logic [EXT_W-1:0]      length_ext;
   logic [CNT_W-1:0]      len_eff;
   logic [ADDR_W-1:0]     idx;
   logic [CNT_W-1:0]      idx_next;
   logic                  idx_unwritten;
   logic                  rising_next;
   logic [POSITION_W-1:0] pos_next;
   logic [WORD_W-1:0]     wr_word;
   logic [WORD_W-1:0]     rd_word;

   assign rsp_xfer   = out_valid_ff && rsp_ch.ready;
   assign s1_advance = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign req_xfer   = req_ch.valid && req_ch.ready;
   assign is_sample  = (req_ch.func == FUNC_SAMPLE);

   // effective length: zero acts as one, clamp to store depth
   always_comb begin
      length_ext = EXT_W'(length_ff);
      if (length_ext == '0) begin
         len_eff = CNT_W'(1);
      end else if (length_ext > EXT_W'(STORE_DEPTH)) begin
         len_eff = CNT_W'(STORE_DEPTH);
      end else begin
         len_eff = length_ext[CNT_W-1:0];
      end
   end

   always_comb begin
      idx           = (CNT_W'(ptr_ff) >= len_eff) ? '0 : ptr_ff;
      idx_next      = CNT_W'(idx) + CNT_W'(1);
      idx_unwritten = (CNT_W'(idx) >= fill_ff);
      wr_word       = WORD_W'(req_ch.sample_in) + SAMPLE_BIAS;
   end

   always_comb begin
      rising_next = rising_ff;
      if (pos_ff >= sweep_max_ff) begin
         rising_next = 1'b0;
      end
      if (pos_ff == '0) begin
         rising_next = 1'b1;
      end
      pos_next = rising_next ? pos_ff + POSITION_W'(1) : pos_ff - POSITION_W'(1);
   end

   swdl_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_xfer && is_sample),
      .wr_addr (idx),
      .wr_data (wr_word),
      .rd_en   (req_xfer && is_sample),
      .rd_addr (idx),
      .rd_data (rd_word)
   );

   always_comb begin
      length_in    = length_ff;
      offset_in    = offset_ff;
      sweep_max_in = sweep_max_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      rising_in    = rising_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DELAY_LENGTH: begin
               length_in = csr_wr_data[LENGTH_W-1:0];
               ptr_in    = '0;
            end
            CSR_SWEEP_OFFSET: offset_in    = csr_wr_data[OFFSET_W-1:0];
            CSR_SWEEP_MAX:    sweep_max_in = csr_wr_data[POSITION_W-1:0];
            default: ;
         endcase
      end
      if (req_xfer) begin
         if (is_sample) begin
            ptr_in = (idx_next >= len_eff) ? '0 : idx_next[ADDR_W-1:0];
            if (idx_unwritten) begin
               fill_in = fill_ff + CNT_W'(1);
            end
         end else begin
            pos_in    = pos_next;
            rising_in = rising_next;
         end
      end
   end

   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_kind_in     = s1_kind_ff;
      s1_interval_in = s1_interval_ff;
      s1_blank_in    = s1_blank_ff;
      if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_xfer) begin
         s1_valid_in    = 1'b1;
         s1_kind_in     = req_ch.func;
         s1_interval_in = is_sample ? '0
                        : BASE_INTERVAL + INTERVAL_W'(offset_ff) + INTERVAL_W'(pos_next);
         s1_blank_in    = !is_sample || idx_unwritten;
      end
   end

   always_comb begin
      out_valid_in    = out_valid_ff;
      out_kind_in     = out_kind_ff;
      out_interval_in = out_interval_ff;
      out_word_in     = out_word_ff;
      if (rsp_xfer) begin
         out_valid_in = 1'b0;
      end
      if (s1_valid_ff && s1_advance) begin
         out_valid_in    = 1'b1;
         out_kind_in     = s1_kind_ff;
         out_interval_in = s1_interval_ff;
         out_word_in     = s1_blank_ff ? '0 : rd_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= LENGTH_RESET;
         offset_ff    <= OFFSET_RESET;
         sweep_max_ff <= SWEEP_MAX_RESET;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         rising_ff    <= 1'b1;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         offset_ff    <= offset_in;
         sweep_max_ff <= sweep_max_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         rising_ff    <= rising_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff      <= s1_kind_in;
      s1_interval_ff  <= s1_interval_in;
      s1_blank_ff     <= s1_blank_in;
      out_kind_ff     <= out_kind_in;
      out_interval_ff <= out_interval_in;
      out_word_ff     <= out_word_in;
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.result_kind     = out_kind_ff;
   assign rsp_ch.sample_interval = out_interval_ff;
   assign rsp_ch.delayed_sample  = out_word_ff;
   assign rsp_ch.pin_word        = pin_map(out_word_ff);

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(STORE_DEPTH))
      else $error("fill count beyond store depth");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(ptr_ff) < len_eff)
      else $error("write pointer outside delay length");

   a_ptr_in_fill: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(ptr_ff) <= fill_ff)
      else $error("write pointer beyond written region");

   a_sweep_step: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !is_sample |=>
         (pos_ff == $past(pos_ff) + POSITION_W'(1)) ||
         (pos_ff == $past(pos_ff) - POSITION_W'(1)))
      else $error("sweep position moved by other than one");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_ch.ready |=> $stable(out_word_ff))
      else $error("pending result overwritten");

endmodule

// ----- bench/swdl_result_check.sv -----
module swdl_result_check
   import swdl_pkg::*;
#(
   parameter int DEPTH = STORE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   swdl_req_if                    req_mon,
   swdl_rsp_if                    rsp_mon,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   output int                     fail_count,
   output int                     outstanding
);

   typedef struct packed {
      logic                  kind;
      logic [INTERVAL_W-1:0] interval;
      logic [WORD_W-1:0]     delayed;
      logic [PIN_W-1:0]      pins;
   } flanger_out_type;

   logic [WORD_W-1:0]     delay_mem [DEPTH];
   logic [LENGTH_W-1:0]   length_reg;
   logic [OFFSET_W-1:0]   offset_reg;
   logic [POSITION_W-1:0] sweep_max_reg;
   logic [POSITION_W-1:0] position;
   logic                  rising;
   int unsigned           wr_ptr;
   flanger_out_type       expected_outputs [$];
   int                    errors = 0;

   // one item through the delay line / sweep, returns the output it must produce
   function automatic flanger_out_type step_delay_line(input logic func,
                                                       input logic [SAMPLE_W-1:0] sample);
      flanger_out_type   r;
      int unsigned       eff;
      int unsigned       idx;
      logic [WORD_W-1:0] word;
      r = '0;
      if (func == FUNC_SWEEP) begin
         if (position >= sweep_max_reg) rising = 1'b0;
         if (position == '0) rising = 1'b1;
         position = rising ? position + 1'b1 : position - 1'b1;
         r.kind = FUNC_SWEEP;
         r.interval = BASE_INTERVAL + INTERVAL_W'(offset_reg) + INTERVAL_W'(position);
      end else begin
         eff = (length_reg == '0) ? 1 : ((length_reg > DEPTH) ? DEPTH : length_reg);
         idx = (wr_ptr >= eff) ? 0 : wr_ptr;
         word = delay_mem[idx];
         r.kind = FUNC_SAMPLE;
         r.delayed = word;
         r.pins[11:1] = word[10:0];
         r.pins[15] = word[11];
         delay_mem[idx] = WORD_W'(sample) + SAMPLE_BIAS;
         wr_ptr = (idx + 1 >= eff) ? 0 : idx + 1;
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      flanger_out_type want;
      if (reset) begin
         length_reg    = LENGTH_RESET;
         offset_reg    = OFFSET_RESET;
         sweep_max_reg = SWEEP_MAX_RESET;
         position      = '0;
         rising        = 1'b1;
         wr_ptr        = 0;
         for (int i = 0; i < DEPTH; i++) delay_mem[i] = '0;
         expected_outputs.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DELAY_LENGTH: begin
                  length_reg = csr_wr_data[LENGTH_W-1:0];
                  wr_ptr = 0;
               end
               CSR_SWEEP_OFFSET: offset_reg = csr_wr_data[OFFSET_W-1:0];
               CSR_SWEEP_MAX: sweep_max_reg = csr_wr_data[POSITION_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_outputs.push_back(step_delay_line(req_mon.func, req_mon.sample_in));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_outputs.size() == 0) begin
               $error("result transfer with no expected output");
               errors++;
            end else begin
               want = expected_outputs.pop_front();
               check_field("result_kind", 32'(want.kind), 32'(rsp_mon.result_kind));
               check_field("sample_interval", 32'(want.interval),
                           32'(rsp_mon.sample_interval));
               check_field("delayed_sample", 32'(want.delayed), 32'(rsp_mon.delayed_sample));
               check_field("pin_word", 32'(want.pins), 32'(rsp_mon.pin_word));
            end
         end
      end
      fail_count  <= errors;
      outstanding <= expected_outputs.size();
   end

endmodule

// ----- bench/tb_swept_clock_delay_line.sv -----
module tb_swept_clock_delay_line;
   import swdl_pkg::*;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   localparam int CYCLE_LIMIT = 200000;
   // word extremes: 0x7FF, 0x800, 0xFFF and 4195 once biased
   localparam logic [SAMPLE_W-1:0] CORNER_SAMPLES [9] =
      '{12'd0, 12'd1947, 12'd1948, 12'd3995, 12'd4095, 12'hAAA, 12'h555, 12'd0, 12'd1};

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;
   int                     fail_count;
   int                     outstanding;
   int unsigned            cycle_count = 0;
   idle_mode_type          idle_mode = IDLE_NONE;

   swdl_req_if req_ch ();
   swdl_rsp_if rsp_ch ();

   always #4 clock = ~clock;

   swept_clock_delay_line u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   swdl_result_check u_result_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic int send_gap_pct(input idle_mode_type m);
      return (m == IDLE_SENDER) ? 63 : ((m == IDLE_BOTH) ? 6 : 0);
   endfunction

   function automatic int stall_pct(input idle_mode_type m);
      return (m == IDLE_RECEIVER) ? 63 : ((m == IDLE_BOTH) ? 6 : 0);
   endfunction

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99, 0) >= stall_pct(idle_mode));
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_item(input func_type f, input logic [SAMPLE_W-1:0] s);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_gap_pct(idle_mode)) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= f;
      req_ch.sample_in <= s;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] len,
                            input logic [CSR_DATA_W-1:0] off,
                            input logic [CSR_DATA_W-1:0] smax);
      write_reg(CSR_DELAY_LENGTH, len);
      write_reg(CSR_SWEEP_OFFSET, off);
      write_reg(CSR_SWEEP_MAX, smax);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // stop sending, let every transfer come back, then pause before returning
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_phase(input logic [CSR_DATA_W-1:0] len,
                               input logic [CSR_DATA_W-1:0] off,
                               input logic [CSR_DATA_W-1:0] smax,
                               input idle_mode_type mode, input int count);
      configure(len, off, smax);
      idle_mode = mode;
      repeat (count)
         send_item(func_type'($urandom_range(1, 0)), SAMPLE_W'($urandom_range(4095, 0)));
      drain();
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.func      <= FUNC_SWEEP;
      req_ch.sample_in <= '0;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_DELAY_LENGTH;
      csr_wr_data      <= '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset settings, untouched store reads back zero
      for (int i = 0; i < 4; i++) begin
         send_item(FUNC_SWEEP, '0);
         send_item(FUNC_SAMPLE, SAMPLE_W'(i * 1000));
      end
      drain();

      // zero length acts as one entry, zero sweep max alternates 0/1
      configure(16'd0, 16'd0, 16'd0);
      foreach (CORNER_SAMPLES[i]) send_item(FUNC_SAMPLE, CORNER_SAMPLES[i]);
      repeat (4) send_item(FUNC_SWEEP, 12'hFFF);
      send_item(FUNC_SAMPLE, 12'd4095);
      send_item(FUNC_SAMPLE, 12'd0);
      drain();

      random_phase(16'd3, 16'd65535, 16'd5, IDLE_SENDER, 110);
      random_phase(16'd16383, 16'd1234, 16'd1, IDLE_RECEIVER, 60);
      random_phase(16'd8192, 16'd2000, 16'd8191, IDLE_BOTH, 40);
      random_phase(16'd1, 16'd777, 16'd13, IDLE_NONE, 110);
      random_phase(16'd7, 16'd65535, 16'd5710, IDLE_SENDER, 100);
      random_phase(16'd2, 16'd0, 16'd3, IDLE_RECEIVER, 120);
      random_phase(16'd5, 16'd300, 16'd0, IDLE_BOTH, 90);

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- swept_clock_delay_line.f -----
design/swdl_pkg.sv
design/swdl_req_if.sv
design/swdl_rsp_if.sv
design/swdl_ram.sv
design/swept_clock_delay_line.sv
bench/swdl_result_check.sv
bench/tb_swept_clock_delay_line.sv
